FILE: design/fitn_pkg.sv
// ---------------------------------------------------------------------------
// fitn_pkg
// Shared types and constants of the frame interval timeline normaliser.
// ---------------------------------------------------------------------------
`default_nettype none

package fitn_pkg;

    localparam int unsigned FrameWidth  = 32;
    localparam int unsigned TagWidth    = 16;
    localparam int unsigned RenderWidth = 40;

    localparam int unsigned CfgIndexWidth = 1;
    localparam int unsigned CfgDataWidth  = 1;

    localparam logic [CfgIndexWidth-1:0] RegTrimOverlaps = 1'd0;
    localparam logic [CfgIndexWidth-1:0] RegFillGaps     = 1'd1;

    // result slots in emission order
    localparam int unsigned NumSlots  = 3;
    localparam int unsigned SlotHeld  = 0;
    localparam int unsigned SlotGap   = 1;
    localparam int unsigned SlotFinal = 2;

    // smallest hole that becomes a gap interval
    localparam logic [FrameWidth:0] GapMinFrames = 33'd2;

    typedef struct packed {
        logic                  trim_overlaps;
        logic                  fill_gaps;
    } cfg_t;

    typedef struct packed {
        logic [FrameWidth-1:0] first_frame;
        logic [FrameWidth-1:0] last_frame;
        logic [TagWidth-1:0]   tag;
        logic                  final_item;
    } item_t;

    typedef struct packed {
        logic                  is_gap;
        logic [FrameWidth-1:0] first_frame;
        logic [FrameWidth-1:0] last_frame;
        logic [TagWidth-1:0]   tag;
    } entry_t;

    typedef struct packed {
        logic [NumSlots-1:0]             mask;
        entry_t [NumSlots-1:0]           slots;
    } plan_t;

    typedef struct packed {
        logic                   is_gap;
        logic [FrameWidth-1:0]  out_start;
        logic [FrameWidth-1:0]  out_end;
        logic [TagWidth-1:0]    out_tag;
        logic [RenderWidth-1:0] render_first;
        logic [RenderWidth-1:0] render_last;
        logic                   run_last;
        logic                   stream_done;
    } result_t;

endpackage

`default_nettype wire

FILE: design/fitn_trim.sv
// ---------------------------------------------------------------------------
// fitn_trim
// Holds the pending interval, trims overlaps against the incoming one and
// builds the list of up to three intervals that the transaction releases.
// ---------------------------------------------------------------------------
`default_nettype none

module fitn_trim
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire fitn_pkg::cfg_t  cfg,
    input  wire fitn_pkg::item_t item,
    input  wire logic           take,
    output fitn_pkg::plan_t     plan
);
    import fitn_pkg::*;

    logic                  held_valid_reg, held_valid_next;
    logic [FrameWidth-1:0] held_start_reg, held_start_next;
    logic [FrameWidth-1:0] held_end_reg,   held_end_next;
    logic [TagWidth-1:0]   held_tag_reg,   held_tag_next;

    logic                  overlap;
    logic [FrameWidth:0]   ov;
    logic [FrameWidth-1:0] tp;
    logic [FrameWidth:0]   tc;
    logic [FrameWidth-1:0] pe;
    logic [FrameWidth-1:0] he_trim;
    logic [FrameWidth:0]   ns;
    logic [FrameWidth-1:0] cs_min;
    logic [FrameWidth:0]   p1;
    logic [FrameWidth-1:0] cs_push;
    logic [FrameWidth-1:0] he2;
    logic [FrameWidth-1:0] cs2;
    logic                  gap;

    always_comb
    begin
        overlap = cfg.trim_overlaps && held_valid_reg && (item.first_frame <= held_end_reg);
        ov      = {1'b0, held_end_reg} - {1'b0, item.first_frame} + 33'd1;
        tp      = ov[FrameWidth:1];
        tc      = ov - {1'b0, tp};
        pe      = held_end_reg - tp;
        he_trim = (pe > held_start_reg) ? pe : held_start_reg;
        ns      = {1'b0, item.first_frame} + tc;
        cs_min  = (ns < {1'b0, item.last_frame}) ? ns[FrameWidth-1:0] : item.last_frame;
        p1      = {1'b0, he_trim} + 33'd1;
        if (cs_min <= he_trim)
        begin
            cs_push = (p1 < {1'b0, item.last_frame}) ? p1[FrameWidth-1:0] : item.last_frame;
        end
        else
        begin
            cs_push = cs_min;
        end
        he2 = overlap ? he_trim : held_end_reg;
        cs2 = overlap ? cs_push : item.first_frame;
        gap = held_valid_reg && cfg.fill_gaps
            && ({1'b0, cs2} >= ({1'b0, he2} + 33'd1 + GapMinFrames));
    end

    always_comb
    begin
        plan.mask[SlotHeld]  = held_valid_reg;
        plan.mask[SlotGap]   = gap;
        plan.mask[SlotFinal] = item.final_item;

        plan.slots[SlotHeld].is_gap      = 1'b0;
        plan.slots[SlotHeld].first_frame = held_start_reg;
        plan.slots[SlotHeld].last_frame  = he2;
        plan.slots[SlotHeld].tag         = held_tag_reg;

        plan.slots[SlotGap].is_gap       = 1'b1;
        plan.slots[SlotGap].first_frame  = he2 + 32'd1;
        plan.slots[SlotGap].last_frame   = cs2 - 32'd1;
        plan.slots[SlotGap].tag          = '0;

        plan.slots[SlotFinal].is_gap      = 1'b0;
        plan.slots[SlotFinal].first_frame = cs2;
        plan.slots[SlotFinal].last_frame  = item.last_frame;
        plan.slots[SlotFinal].tag         = item.tag;
    end

    always_comb
    begin
        held_valid_next = held_valid_reg;
        held_start_next = held_start_reg;
        held_end_next   = held_end_reg;
        held_tag_next   = held_tag_reg;
        if (take)
        begin
            if (item.final_item)
            begin
                held_valid_next = 1'b0;
                held_start_next = '0;
                held_end_next   = '0;
                held_tag_next   = '0;
            end
            else
            begin
                held_valid_next = 1'b1;
                held_start_next = cs2;
                held_end_next   = item.last_frame;
                held_tag_next   = item.tag;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_valid_reg <= 1'b0;
            held_start_reg <= '0;
            held_end_reg   <= '0;
            held_tag_reg   <= '0;
        end
        else
        begin
            held_valid_reg <= held_valid_next;
            held_start_reg <= held_start_next;
            held_end_reg   <= held_end_next;
            held_tag_reg   <= held_tag_next;
        end
    end

endmodule

`default_nettype wire

FILE: design/fitn_emit.sv
// ---------------------------------------------------------------------------
// fitn_emit
// Plan register and output register: releases one interval per cycle while the
// output is not stalled and places it on the render timeline from the running cursor.
// ---------------------------------------------------------------------------
`default_nettype none

module fitn_emit
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire fitn_pkg::plan_t plan,
    input  wire logic            load,
    input  wire logic            out_stall,
    output logic                 load_ok,
    output logic                 out_valid,
    output fitn_pkg::result_t    result
);
    import fitn_pkg::*;

    plan_t                  plan_reg, plan_next;
    logic                   out_valid_reg, out_valid_next;
    result_t                result_reg, result_next;
    logic [RenderWidth-1:0] cursor_reg, cursor_next;

    logic                   out_free;
    logic                   fire;
    logic [NumSlots-1:0]    sel;
    logic [NumSlots-1:0]    rest;
    entry_t                 pick;
    logic [FrameWidth-1:0]  span;

    always_comb
    begin
        out_free = !out_valid_reg || !out_stall;
        fire     = out_free && (plan_reg.mask != '0);
        sel      = plan_reg.mask & (~plan_reg.mask + 3'd1);
        rest     = plan_reg.mask & ~sel;
        load_ok  = (plan_reg.mask == '0) || (fire && (rest == '0));

        pick = '0;
        for (int i = 0; i < NumSlots; i++)
        begin
            if (sel[i])
            begin
                pick = pick | plan_reg.slots[i];
            end
        end
        span = (pick.last_frame >= pick.first_frame) ? (pick.last_frame - pick.first_frame) : '0;
    end

    always_comb
    begin
        plan_next      = plan_reg;
        out_valid_next = out_valid_reg && out_stall;
        result_next    = result_reg;
        cursor_next    = cursor_reg;

        if (fire)
        begin
            plan_next.mask           = rest;
            out_valid_next           = 1'b1;
            result_next.is_gap       = pick.is_gap;
            result_next.out_start    = pick.first_frame;
            result_next.out_end      = pick.last_frame;
            result_next.out_tag      = pick.tag;
            result_next.render_first = cursor_reg;
            result_next.render_last  = cursor_reg + {8'd0, span};
            result_next.run_last     = (rest == '0);
            result_next.stream_done  = sel[SlotFinal];
            cursor_next = sel[SlotFinal] ? '0 : (cursor_reg + {8'd0, span} + 40'd1);
        end
        if (load)
        begin
            plan_next = plan;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            plan_reg      <= '0;
            out_valid_reg <= 1'b0;
            cursor_reg    <= '0;
        end
        else
        begin
            plan_reg      <= plan_next;
            out_valid_reg <= out_valid_next;
            cursor_reg    <= cursor_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign out_valid = out_valid_reg;
    assign result    = result_reg;

endmodule

`default_nettype wire

FILE: design/frame_interval_timeline_normalizer_core.sv
// ---------------------------------------------------------------------------
// frame_interval_timeline_normalizer_core
// Holds one source interval back, trims overlaps, inserts gaps and lays
// every released interval onto a contiguous render timeline.
// ---------------------------------------------------------------------------
// One input transaction is taken per cycle as long as each releases at most
// one interval and the output is not stalled; a transaction that releases
// n intervals (0 to 3) keeps the input stalled until the single output
// register has released its last interval. Results pass through the input
// register, the plan register and the output register. The first interval
// of a stream releases nothing until its successor arrives; a final input
// flushes it and restarts the cursor.
`default_nettype none

module frame_interval_timeline_normalizer_core
(
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,

    input  wire logic                                  cfg_we,
    input  wire logic [fitn_pkg::CfgIndexWidth-1:0]    cfg_index,
    input  wire logic [fitn_pkg::CfgDataWidth-1:0]     cfg_data,

    input  wire logic                                  in_valid,
    output logic                                       in_stall,
    input  wire logic [fitn_pkg::FrameWidth-1:0]       src_start,
    input  wire logic [fitn_pkg::FrameWidth-1:0]       src_end,
    input  wire logic [fitn_pkg::TagWidth-1:0]         item_tag,
    input  wire logic                                  final_item,

    output logic                                       out_valid,
    input  wire logic                                  out_stall,
    output logic                                       is_gap,
    output logic [fitn_pkg::FrameWidth-1:0]            out_start,
    output logic [fitn_pkg::FrameWidth-1:0]            out_end,
    output logic [fitn_pkg::TagWidth-1:0]              out_tag,
    output logic [fitn_pkg::RenderWidth-1:0]           render_first,
    output logic [fitn_pkg::RenderWidth-1:0]           render_last,
    output logic                                       run_last,
    output logic                                       stream_done
);
    import fitn_pkg::*;

    cfg_t    cfg_reg, cfg_next;
    logic    in_full_reg, in_full_next;
    item_t   in_item_reg, in_item_next;
    logic    in_accept;
    logic    in_take;
    logic    load_ok;
    plan_t   plan;
    result_t result;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                RegTrimOverlaps: cfg_next.trim_overlaps = cfg_data[0];
                RegFillGaps:     cfg_next.fill_gaps     = cfg_data[0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        in_take   = in_full_reg && load_ok;
        in_stall  = in_full_reg && !load_ok;
        in_accept = in_valid && !in_stall;

        in_full_next = in_accept ? 1'b1 : (in_take ? 1'b0 : in_full_reg);
        in_item_next = in_item_reg;
        if (in_accept)
        begin
            in_item_next.first_frame = src_start;
            in_item_next.last_frame  = src_end;
            in_item_next.tag         = item_tag;
            in_item_next.final_item  = final_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.trim_overlaps <= 1'b1;
            cfg_reg.fill_gaps     <= 1'b1;
            in_full_reg           <= 1'b0;
        end
        else
        begin
            cfg_reg     <= cfg_next;
            in_full_reg <= in_full_next;
        end
    end

    always_ff @(posedge clk)
    begin
        in_item_reg <= in_item_next;
    end

    fitn_trim u_trim
    (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_reg),
        .item  (in_item_reg),
        .take  (in_take),
        .plan  (plan)
    );

    fitn_emit u_emit
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .plan      (plan),
        .load      (in_take),
        .out_stall (out_stall),
        .load_ok   (load_ok),
        .out_valid (out_valid),
        .result    (result)
    );

    assign is_gap       = result.is_gap;
    assign out_start    = result.out_start;
    assign out_end      = result.out_end;
    assign out_tag      = result.out_tag;
    assign render_first = result.render_first;
    assign render_last  = result.render_last;
    assign run_last     = result.run_last;
    assign stream_done  = result.stream_done;

endmodule

`default_nettype wire

FILE: design/fitn_checker.sv
// ---------------------------------------------------------------------------
// fitn_checker
// Port-level checks of the normaliser: timeline continuity, gap and flush
// markers, and output hold under stall.
// ---------------------------------------------------------------------------
`default_nettype none

module fitn_checker
(
    input wire logic                                clk,
    input wire logic                                rst_n,
    input wire logic                                out_valid,
    input wire logic                                out_stall,
    input wire logic                                is_gap,
    input wire logic [fitn_pkg::FrameWidth-1:0]     out_start,
    input wire logic [fitn_pkg::FrameWidth-1:0]     out_end,
    input wire logic [fitn_pkg::TagWidth-1:0]       out_tag,
    input wire logic [fitn_pkg::RenderWidth-1:0]    render_first,
    input wire logic [fitn_pkg::RenderWidth-1:0]    render_last,
    input wire logic                                run_last,
    input wire logic                                stream_done
);
    import fitn_pkg::*;

    logic [RenderWidth-1:0] expect_first_reg;

    // next render frame expected on the timeline
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expect_first_reg <= '0;
        end
        else if (out_valid && !out_stall)
        begin
            expect_first_reg <= stream_done ? '0 : (render_last + 40'd1);
        end
    end

    a_timeline_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> render_first == expect_first_reg)
        else $error("render timeline not contiguous");

    a_done_is_run_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && stream_done |-> run_last)
        else $error("stream end without run end");

    a_gap_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && is_gap |-> out_tag == '0 && !stream_done && out_end > out_start)
        else $error("malformed gap transaction");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(render_first) && $stable(out_start))
        else $error("stalled result changed");

endmodule

bind frame_interval_timeline_normalizer_core fitn_checker u_fitn_checker (.*);

`default_nettype wire
